/* src/drt_pkg.sv */
// ----------------------------------------------------------------------------
// drt_pkg: shared types and constants for the dated reminder table
// Field widths, operation codes, register indexes and month lengths.
// ----------------------------------------------------------------------------
package drt_pkg;

    localparam int MaxReminders = 32;
    localparam int IdxW         = $clog2(MaxReminders);
    localparam int CntW         = $clog2(MaxReminders + 1);

    // operation codes
    localparam logic [1:0] OP_ADD     = 2'd0;
    localparam logic [1:0] OP_ADVANCE = 2'd1;
    localparam logic [1:0] OP_LIST    = 2'd2;

    // configuration register indexes
    localparam logic CFG_START_MONTH = 1'b0;
    localparam logic CFG_START_DAY   = 1'b1;

    typedef struct packed {
        logic [1:0]  operation;
        logic [3:0]  rem_month;
        logic [4:0]  rem_day;
        logic [4:0]  rem_hour;
        logic [5:0]  rem_minute;
        logic [15:0] rem_message;
    } t_in_item;

    typedef struct packed {
        logic [3:0]  today_month;
        logic [4:0]  today_day;
        logic        match_valid;
        logic [4:0]  out_hour;
        logic [5:0]  out_minute;
        logic [15:0] out_message;
        logic        store_full;
        logic        last;
    } t_out_item;

    typedef struct packed {
        logic [3:0]  month;
        logic [4:0]  day;
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [15:0] message;
    } t_entry;

    // days in a month; out of range months count as 31 days
    function automatic logic [4:0] month_len(input logic [3:0] m);
        case (m)
            4'd2:                      month_len = 5'd28;
            4'd4, 4'd6, 4'd9, 4'd11:   month_len = 5'd30;
            default:                   month_len = 5'd31;
        endcase
    endfunction

endpackage

/* src/drt_if.sv */
// ----------------------------------------------------------------------------
// drt_if: valid/ready channels of the dated reminder table
// Input item, result item and configuration write channels.
// ----------------------------------------------------------------------------
interface drt_in_if import drt_pkg::*; ();
    logic     valid;
    logic     ready;
    t_in_item data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface drt_out_if import drt_pkg::*; ();
    logic      valid;
    logic      ready;
    t_out_item data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface drt_cfg_if ();
    logic        valid;
    logic        ready;
    logic        index;
    logic [15:0] wdata;
    modport source (output valid, output index, output wdata, input ready);
    modport sink   (input valid, input index, input wdata, output ready);
endinterface

/* src/dated_reminder_table.sv */
// ----------------------------------------------------------------------------
// dated_reminder_table: current date and a time ordered reminder table
// ----------------------------------------------------------------------------
// One transaction is handled at a time by a small sequencer around a
// 32-entry memory with one write port and a registered read port. The input
// is ready only while the sequencer is idle and the result register is free.
// - Add: stored entries are read in order up to the slot. Then each later
//   entry moves up by a read and a write, and a last write stores the
//   new entry.
// - Dropped add or unknown operation: the result is loaded at the accept edge.
// - List: every stored entry is read once. The latest match is held back one
//   step so that the final one can carry last. The scan stalls while a result
//   waits on the output.
// - Advance: the date steps at the accept edge and S_OUT loads the result.
// ----------------------------------------------------------------------------
module dated_reminder_table import drt_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    drt_in_if.sink    in_ch,
    drt_out_if.source out_ch,
    drt_cfg_if.sink   cfg_ch
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SCAN  = 3'd1;  // add: find slot
    localparam logic [2:0] S_SHRD  = 3'd2;  // add: read entry to move
    localparam logic [2:0] S_SHWR  = 3'd3;  // add: write it one up
    localparam logic [2:0] S_LIST  = 3'd4;  // list: scan entries
    localparam logic [2:0] S_OUT   = 3'd5;  // advance: load result

    logic [2:0]      r_state;
    t_in_item        r_item;
    logic [3:0]      r_month;
    logic [4:0]      r_day;
    logic [CntW-1:0] r_count;
    logic [CntW-1:0] r_ptr;       // address issued
    logic            r_rd_vld;    // read data valid (add keeps its address in r_rd_addr)
    logic [CntW-1:0] r_rd_addr;
    logic            r_held_vld;  // a list match is held back
    t_entry          r_held;
    logic            r_ovalid;
    t_out_item       r_odata;

    logic [2:0]      n_state;
    t_in_item        n_item;
    logic [3:0]      n_month;
    logic [4:0]      n_day;
    logic [CntW-1:0] n_count;
    logic [CntW-1:0] n_ptr;
    logic            n_rd_vld;
    logic [CntW-1:0] n_rd_addr;
    logic            n_held_vld;
    t_entry          n_held;
    logic            n_ovalid;
    t_out_item       n_odata;

    t_entry          r_mem [MaxReminders];
    t_entry          r_rdata;
    logic            mem_we;
    logic [IdxW-1:0] mem_waddr;
    t_entry          mem_wdata;
    logic            mem_re;
    logic [IdxW-1:0] mem_raddr;

    logic out_free;
    logic in_fire;
    logic cfg_fire;
    logic later;
    logic match;
    logic [4:0] mlen;

    assign out_free     = !r_ovalid || out_ch.ready;
    assign in_ch.ready  = (r_state == S_IDLE) && out_free;
    assign in_fire      = in_ch.valid && in_ch.ready;
    assign cfg_ch.ready = (r_state == S_IDLE) && !in_ch.valid;
    assign cfg_fire     = cfg_ch.valid && cfg_ch.ready;
    assign out_ch.valid = r_ovalid;
    assign out_ch.data  = r_odata;

    // memory: one write and one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            r_rdata <= r_mem[mem_raddr];
        end
    end

    // single shared compare unit
    assign later = (r_item.rem_hour != r_rdata.hour) ? (r_item.rem_hour < r_rdata.hour)
                                                     : (r_item.rem_minute < r_rdata.minute);
    assign match = (r_rdata.month == r_month) && (r_rdata.day == r_day);
    assign mlen  = month_len(r_month);

    // memory port control
    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = r_ptr[IdxW-1:0];
        mem_wdata = r_rdata;
        mem_re    = 1'b0;
        mem_raddr = r_ptr[IdxW-1:0];
        case (r_state)
            S_SCAN: begin
                mem_re = (r_ptr < r_count) && !(r_rd_vld && later);
            end
            S_SHRD: begin
                mem_re    = 1'b1;
                mem_raddr = IdxW'(r_ptr - 1'b1);
            end
            S_SHWR: begin
                mem_we = 1'b1;
                if (r_ptr == r_rd_addr) begin
                    mem_wdata = '{r_item.rem_month, r_item.rem_day, r_item.rem_hour,
                                  r_item.rem_minute, r_item.rem_message};
                end
            end
            S_LIST: begin
                mem_re = (r_ptr < r_count) && out_free;
            end
            default: ;
        endcase
    end

    // sequencer next state
    always_comb begin
        n_state    = r_state;
        n_item     = r_item;
        n_month    = r_month;
        n_day      = r_day;
        n_count    = r_count;
        n_ptr      = r_ptr;
        n_rd_vld   = r_rd_vld;
        n_rd_addr  = r_rd_addr;
        n_held_vld = r_held_vld;
        n_held     = r_held;
        n_ovalid   = r_ovalid && !out_ch.ready;
        n_odata    = r_odata;
        if (cfg_fire) begin
            if (cfg_ch.index == CFG_START_MONTH) begin
                n_month = cfg_ch.wdata[3:0];
            end else begin
                n_day = cfg_ch.wdata[4:0];
            end
        end
        case (r_state)
            S_IDLE: begin
                if (in_fire) begin
                    n_item     = in_ch.data;
                    n_ptr      = '0;
                    n_rd_vld   = 1'b0;
                    n_held_vld = 1'b0;
                    n_odata    = '{r_month, r_day, 1'b0, 5'd0, 6'd0, 16'd0, 1'b0, 1'b1};
                    case (in_ch.data.operation)
                        OP_ADD: begin
                            if (r_count >= CntW'(MaxReminders)) begin
                                n_odata.store_full = 1'b1;
                                n_ovalid = 1'b1;
                            end else begin
                                n_state = S_SCAN;
                            end
                        end
                        OP_ADVANCE: begin
                            n_state = S_OUT;
                            if (r_day + 5'd1 > mlen || r_day == 5'd31) begin
                                n_day   = 5'd1;
                                n_month = (r_month >= 4'd12) ? 4'd1 : r_month + 4'd1;
                            end else begin
                                n_day = r_day + 5'd1;
                            end
                        end
                        OP_LIST: n_state = S_LIST;
                        default: n_ovalid = 1'b1;
                    endcase
                end
            end
            S_OUT: begin
                // advance result carries the new date
                n_odata.today_month = r_month;
                n_odata.today_day   = r_day;
                n_ovalid = 1'b1;
                n_state  = S_IDLE;
            end
            S_SCAN: begin
                if (r_rd_vld && later) begin
                    // slot is r_rd_addr; move entries count-1 .. slot up
                    n_ptr   = r_count;
                    n_state = S_SHRD;
                end else if (r_ptr < r_count) begin
                    n_rd_addr = r_ptr;
                    n_rd_vld  = 1'b1;
                    n_ptr     = r_ptr + 1'b1;
                end else begin
                    n_rd_addr = r_count;
                    n_ptr     = r_count;
                    n_state   = S_SHWR;
                end
            end
            S_SHRD: begin
                n_state = S_SHWR;
            end
            S_SHWR: begin
                if (r_ptr == r_rd_addr) begin
                    n_count  = r_count + 1'b1;
                    n_ovalid = 1'b1;
                    n_state  = S_IDLE;
                end else begin
                    n_ptr   = r_ptr - 1'b1;
                    n_state = (r_ptr - 1'b1 == r_rd_addr) ? S_SHWR : S_SHRD;
                end
            end
            S_LIST: begin
                if (out_free) begin
                    n_rd_vld = mem_re;
                    if (mem_re) begin
                        n_ptr = r_ptr + 1'b1;
                    end
                    if (r_rd_vld && match) begin
                        // hold the new match, show the one held before
                        n_held_vld = 1'b1;
                        n_held     = r_rdata;
                        if (r_held_vld) begin
                            n_ovalid = 1'b1;
                            n_odata  = '{r_month, r_day, 1'b1, r_held.hour,
                                         r_held.minute, r_held.message, 1'b0, 1'b0};
                        end
                    end else if (!r_rd_vld && !mem_re) begin
                        // scan done: final match or the empty result
                        n_ovalid = 1'b1;
                        n_state  = S_IDLE;
                        if (r_held_vld) begin
                            n_odata = '{r_month, r_day, 1'b1, r_held.hour,
                                        r_held.minute, r_held.message, 1'b0, 1'b1};
                        end else begin
                            n_odata = '{r_month, r_day, 1'b0, 5'd0, 6'd0,
                                        16'd0, 1'b0, 1'b1};
                        end
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_month    <= 4'd1;
            r_day      <= 5'd1;
            r_count    <= '0;
            r_ovalid   <= 1'b0;
            r_rd_vld   <= 1'b0;
            r_held_vld <= 1'b0;
            r_ptr      <= '0;
        end else begin
            r_state    <= n_state;
            r_month    <= n_month;
            r_day      <= n_day;
            r_count    <= n_count;
            r_ovalid   <= n_ovalid;
            r_rd_vld   <= n_rd_vld;
            r_held_vld <= n_held_vld;
            r_ptr      <= n_ptr;
        end
    end

    // data registers
    always_ff @(posedge i_clk) begin
        r_item    <= n_item;
        r_rd_addr <= n_rd_addr;
        r_held    <= n_held;
        r_odata   <= n_odata;
    end

endmodule

/* tb/drt_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// drt_checker: result checker for the dated reminder table
// Watches the input, result and configuration channels, keeps its own copy
// of the date and the reminder table, queues the expected results of each
// accepted transaction and compares every accepted result against them.
// ----------------------------------------------------------------------------
module drt_checker import drt_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    drt_in_if.sink    in_ch,
    drt_out_if.sink   out_ch,
    drt_cfg_if.sink   cfg_ch,
    output int        o_errors,
    output int        o_pending
);

    logic [3:0]  cur_month;
    logic [4:0]  cur_day;
    t_entry      table_q[$];
    t_out_item   expected_q[$];

    function automatic logic [4:0] days_in(input logic [3:0] m);
        logic [4:0] d;
        d = 5'd31;
        if (m == 4'd2) d = 5'd28;
        else if (m == 4'd4 || m == 4'd6 || m == 4'd9 || m == 4'd11) d = 5'd30;
        return d;
    endfunction

    task automatic report(input string what, input int got, input int want);
        $display("mismatch: %s got %0d expected %0d at %0t", what, got, want, $time);
        o_errors++;
    endtask

    function automatic t_out_item blank_result(input logic full);
        t_out_item r;
        r = '0;
        r.today_month = cur_month;
        r.today_day   = cur_day;
        r.store_full  = full;
        r.last        = 1'b1;
        return r;
    endfunction

    // append one expected result
    task automatic add_expected(input t_out_item r);
        expected_q.insert(expected_q.size(), r);
    endtask

    // predict the results of one input transaction
    task automatic predict_item(input t_in_item it);
        t_entry    e;
        t_out_item r;
        t_out_item held;
        bit        have;
        int        pos;
        case (it.operation)
            OP_ADD: begin
                if (table_q.size() >= MaxReminders) begin
                    add_expected(blank_result(1'b1));
                end else begin
                    e = '{it.rem_month, it.rem_day, it.rem_hour, it.rem_minute,
                          it.rem_message};
                    pos = table_q.size();
                    for (int i = 0; i < table_q.size(); i++) begin
                        if ({e.hour, e.minute} < {table_q[i].hour, table_q[i].minute}) begin
                            pos = i;
                            break;
                        end
                    end
                    table_q.insert(pos, e);
                    add_expected(blank_result(1'b0));
                end
            end
            OP_ADVANCE: begin
                if ({1'b0, cur_day} + 6'd1 > {1'b0, days_in(cur_month)}) begin
                    cur_day   = 5'd1;
                    cur_month = (cur_month >= 4'd12) ? 4'd1 : cur_month + 4'd1;
                end else begin
                    cur_day = cur_day + 5'd1;
                end
                add_expected(blank_result(1'b0));
            end
            OP_LIST: begin
                have = 1'b0;
                held = '0;
                foreach (table_q[i]) begin
                    if (table_q[i].month == cur_month && table_q[i].day == cur_day) begin
                        r = blank_result(1'b0);
                        r.last        = 1'b0;
                        r.match_valid = 1'b1;
                        r.out_hour    = table_q[i].hour;
                        r.out_minute  = table_q[i].minute;
                        r.out_message = table_q[i].message;
                        if (have) add_expected(held);
                        held = r;
                        have = 1'b1;
                    end
                end
                if (have) begin
                    held.last = 1'b1;
                    add_expected(held);
                end else begin
                    add_expected(blank_result(1'b0));
                end
            end
            default: add_expected(blank_result(1'b0));
        endcase
    endtask

    // compare one accepted result field by field
    task automatic check_result(input t_out_item got);
        t_out_item want;
        if (expected_q.size() == 0) begin
            report("unexpected result", 1, 0);
            return;
        end
        want = expected_q.pop_front();
        if (got.today_month !== want.today_month)
            report("today_month", got.today_month, want.today_month);
        if (got.today_day !== want.today_day) report("today_day", got.today_day, want.today_day);
        if (got.match_valid !== want.match_valid)
            report("match_valid", got.match_valid, want.match_valid);
        if (got.out_hour !== want.out_hour) report("out_hour", got.out_hour, want.out_hour);
        if (got.out_minute !== want.out_minute)
            report("out_minute", got.out_minute, want.out_minute);
        if (got.out_message !== want.out_message)
            report("out_message", got.out_message, want.out_message);
        if (got.store_full !== want.store_full)
            report("store_full", got.store_full, want.store_full);
        if (got.last !== want.last) report("last", got.last, want.last);
    endtask

    // sample all channels at the clock edge
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            cur_month = 4'd1;
            cur_day   = 5'd1;
            table_q.delete();
            expected_q.delete();
        end else begin
            if (out_ch.valid && out_ch.ready) check_result(out_ch.data);
            if (cfg_ch.valid && cfg_ch.ready) begin
                if (cfg_ch.index == CFG_START_MONTH) cur_month = cfg_ch.wdata[3:0];
                else cur_day = cfg_ch.wdata[4:0];
            end
            if (in_ch.valid && in_ch.ready) predict_item(in_ch.data);
        end
        o_pending = expected_q.size();
    end

    initial o_errors = 0;

endmodule

/* tb/dated_reminder_table_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dated_reminder_table_tb: testbench top for the dated reminder table
// Drives directed and random reminder transactions with random gaps and
// backpressure, rewrites the start date between phases, and reports the
// verdict from the checker's error count.
// ----------------------------------------------------------------------------
module dated_reminder_table_tb;
    import drt_pkg::*;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    int   errors;
    int   pending;
    int   cycles = 0;
    int   send_idle = 0;
    int   recv_idle = 0;
    bit   hold_off = 1'b0;

    drt_in_if  in_ch ();
    drt_out_if out_ch ();
    drt_cfg_if cfg_ch ();

    dated_reminder_table dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .in_ch(in_ch.sink), .out_ch(out_ch.source), .cfg_ch(cfg_ch.sink)
    );

    drt_checker checker_inst (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .in_ch(in_ch.sink), .out_ch(out_ch.sink), .cfg_ch(cfg_ch.sink),
        .o_errors(errors), .o_pending(pending)
    );

    always #5 i_clk = ~i_clk;

    initial begin
        in_ch.valid  = 1'b0;
        in_ch.data   = '0;
        out_ch.ready = 1'b0;
        cfg_ch.valid = 1'b0;
        cfg_ch.index = CFG_START_MONTH;
        cfg_ch.wdata = '0;
    end

    // run limit
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > 400000) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // receiver: random stalls, plus a long hold-off on request
    always @(posedge i_clk) begin
        if (hold_off) out_ch.ready <= 1'b0;
        else out_ch.ready <= ($urandom_range(99) >= recv_idle);
    end

    task automatic write_reg(input logic idx, input logic [15:0] val);
        cfg_ch.index <= idx;
        cfg_ch.wdata <= val;
        cfg_ch.valid <= 1'b1;
        do @(posedge i_clk); while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // valid stays high into the next transaction; drain() drops it
    task automatic send_item(input t_in_item it);
        while ($urandom_range(99) < send_idle) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.data  <= it;
        in_ch.valid <= 1'b1;
        do @(posedge i_clk); while (!in_ch.ready);
    endtask

    task automatic send_op(input logic [1:0] op, input logic [3:0] m, input logic [4:0] d,
                           input logic [4:0] h, input logic [5:0] mi,
                           input logic [15:0] msg);
        t_in_item it;
        it = '{op, m, d, h, mi, msg};
        send_item(it);
    endtask

    task automatic drain();
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (150) @(posedge i_clk);
    endtask

    // random reminders mostly land on the current date or near it
    task automatic random_phase(input int count, input logic [3:0] m0, input logic [4:0] d0);
        int k;
        for (int n = 0; n < count; n++) begin
            k = $urandom_range(99);
            if (k < 55)
                send_op(OP_ADD, ($urandom_range(3) == 0) ? 4'($urandom) : m0,
                        ($urandom_range(3) == 0) ? 5'($urandom) : d0 + 5'($urandom_range(1)),
                        5'($urandom), 6'($urandom), 16'($urandom));
            else if (k < 70) send_op(OP_ADVANCE, 4'($urandom), 5'($urandom), 5'($urandom),
                                     6'($urandom), 16'($urandom));
            else if (k < 97) send_op(OP_LIST, 4'($urandom), 5'($urandom), 5'($urandom),
                                     6'($urandom), 16'($urandom));
            else send_op(2'd3, 4'($urandom), 5'($urandom), 5'($urandom),
                         6'($urandom), 16'($urandom));
        end
    endtask

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: extremes, ties, every operation, wraps
        send_idle = 22;
        recv_idle = 77;
        send_op(OP_LIST, 4'd0, 5'd0, 5'd0, 6'd0, 16'd0);
        send_op(OP_ADD, 4'd1, 5'd1, 5'd23, 6'd59, 16'hFFFF);
        send_op(OP_ADD, 4'd1, 5'd1, 5'd0, 6'd0, 16'h0000);
        send_op(OP_ADD, 4'd1, 5'd1, 5'd12, 6'd30, 16'h1111);
        send_op(OP_ADD, 4'd1, 5'd1, 5'd12, 6'd30, 16'h2222);
        send_op(OP_ADD, 4'd1, 5'd1, 5'd31, 6'd63, 16'h3333);
        send_op(OP_ADD, 4'd15, 5'd31, 5'd7, 6'd7, 16'h4444);
        send_op(OP_LIST, 4'd0, 5'd0, 5'd0, 6'd0, 16'd0);
        send_op(2'd3, 4'hF, 5'h1F, 5'h1F, 6'h3F, 16'hFFFF);
        send_op(OP_ADVANCE, 4'd0, 5'd0, 5'd0, 6'd0, 16'd0);
        send_op(OP_LIST, 4'd0, 5'd0, 5'd0, 6'd0, 16'd0);
        drain();

        // month of 0 on its last day, then 31-day month 15
        write_reg(CFG_START_MONTH, 16'd0);
        write_reg(CFG_START_DAY, 16'd31);
        send_op(OP_ADVANCE, 4'd0, 5'd0, 5'd0, 6'd0, 16'd0);
        drain();
        write_reg(CFG_START_MONTH, 16'd15);
        write_reg(CFG_START_DAY, 16'd0);
        repeat (32) send_op(OP_ADVANCE, 4'd0, 5'd0, 5'd0, 6'd0, 16'd0);
        drain();
        write_reg(CFG_START_MONTH, 16'd12);
        write_reg(CFG_START_DAY, 16'd31);
        send_op(OP_ADVANCE, 4'd0, 5'd0, 5'd0, 6'd0, 16'd0);
        drain();
        write_reg(CFG_START_MONTH, 16'd2);
        write_reg(CFG_START_DAY, 16'd28);
        send_op(OP_LIST, 4'd0, 5'd0, 5'd0, 6'd0, 16'd0);
        send_op(OP_ADVANCE, 4'd0, 5'd0, 5'd0, 6'd0, 16'd0);
        drain();

        // random phase one, then fill the table on one date and overflow it
        write_reg(CFG_START_MONTH, 16'd3);
        write_reg(CFG_START_DAY, 16'd1);
        random_phase(40, 4'd3, 5'd1);
        drain();
        send_idle = 77;
        recv_idle = 22;
        write_reg(CFG_START_MONTH, 16'd3);
        write_reg(CFG_START_DAY, 16'd1);
        repeat (36) send_op(OP_ADD, 4'd3, 5'd1, 5'($urandom_range(3)), 6'($urandom_range(3)),
                            16'($urandom));
        send_op(OP_LIST, 4'd0, 5'd0, 5'd0, 6'd0, 16'd0);
        random_phase(30, 4'd3, 5'd1);
        drain();

        // no idling, with a long receiver hold-off while lists keep coming
        send_idle = 0;
        recv_idle = 0;
        write_reg(CFG_START_MONTH, 16'd3);
        write_reg(CFG_START_DAY, 16'd1);
        fork
            begin
                hold_off <= 1'b1;
                repeat (400) @(posedge i_clk);
                hold_off <= 1'b0;
            end
            repeat (6) send_op(OP_LIST, 4'd0, 5'd0, 5'd0, 6'd0, 16'd0);
        join
        random_phase(40, 4'd3, 5'd1);
        drain();

        if (errors == 0) $display("CHECK OK");
        else $display("CHECK FAILED");
        $finish;
    end

endmodule
